@@ sv/detector_hit_clustering_defines.svh @@
// ----------------------------------------------------------------------------
// Hit clustering assertion macros
// Shared property forms for the clustering block; clocked on aclk and
// disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DETECTOR_HIT_CLUSTERING_DEFINES_SVH
`define DETECTOR_HIT_CLUSTERING_DEFINES_SVH

// same-cycle implication
`define DHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/dhc_pkg.sv @@
// ----------------------------------------------------------------------------
// Hit clustering package
// Shared constants and types for the strip hit clustering block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dhc_pkg;

    localparam int MAX_HITS     = 64;
    localparam int CHANNEL_BITS = 10;

    localparam int CH_W   = 10;
    localparam int TM_W   = 19;
    localparam int TOT_W  = 15;
    localparam int CNT_W  = $clog2(MAX_HITS + 1);
    localparam int MCNT_W = 7;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    localparam logic [CH_W-1:0] CH_MASK = CH_W'((32'd1 << CHANNEL_BITS) - 32'd1);

    // register indexes
    localparam logic [1:0] REG_LAYER  = 2'd0;
    localparam logic [1:0] REG_SIDE   = 2'd1;
    localparam logic [1:0] REG_GAP    = 2'd2;
    localparam logic [1:0] REG_WINDOW = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [TM_W-1:0]  tm;
        logic [TOT_W-1:0] tot;
    } hit_t;

    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic start;
        logic ovf;
        logic hit_en;
        logic flush_en;
    } walk_step_t;

endpackage

@@ sv/dhc_cell.sv @@
// ----------------------------------------------------------------------------
// Hit clustering sort cell
// Holds one stored hit. On insert it keeps, takes its left neighbor or takes
// the new hit so the row stays sorted; on shift it takes its right neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhc_cell import dhc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  hit_t      new_hit,
    input  hit_t      left_hit,
    input  logic      left_valid,
    input  logic      left_gt,
    input  hit_t      right_hit,
    input  logic      right_valid,
    output hit_t      hit,
    output logic      valid,
    output logic      gt
);

    hit_t hit_reg, hit_next;
    logic valid_reg, valid_next;

    always_comb begin
        // strict compare keeps equal keys in arrival order
        gt = valid_reg && ({hit_reg.ch, hit_reg.tm} > {new_hit.ch, new_hit.tm});
        hit_next   = hit_reg;
        valid_next = valid_reg;
        priority if (ctl.shift) begin
            hit_next   = right_hit;
            valid_next = right_valid;
        end else if (ctl.ins && (gt || (!valid_reg && left_valid))) begin
            hit_next   = left_gt ? left_hit : new_hit;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg <= hit_next;
    end

    assign hit   = hit_reg;
    assign valid = valid_reg;

endmodule

@@ sv/dhc_chain.sv @@
// ----------------------------------------------------------------------------
// Hit clustering sort chain
// A row of sort cells. Inserts a hit in channel then time order each cycle that ctl.ins is set, and
// shifts toward the head by one cell per walk step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "detector_hit_clustering_defines.svh"

module dhc_chain import dhc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  hit_t      new_hit,
    output hit_t      head_hit
);

    hit_t                hits   [MAX_HITS];
    logic [MAX_HITS-1:0] valids;
    logic [MAX_HITS-1:0] gts;

    genvar i;
    generate
        for (i = 0; i < MAX_HITS; i++) begin : g_cell
            hit_t lh, rh;
            logic lv, lg, rv;

            if (i == 0) begin : g_head
                assign lh = new_hit;
                assign lv = 1'b1;
                assign lg = 1'b0;
            end else begin : g_body
                assign lh = hits[i-1];
                assign lv = valids[i-1];
                assign lg = gts[i-1];
            end

            if (i == MAX_HITS - 1) begin : g_tail
                assign rh = hits[i];
                assign rv = 1'b0;
            end else begin : g_mid
                assign rh = hits[i+1];
                assign rv = valids[i+1];
            end

            dhc_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .new_hit    (new_hit),
                .left_hit   (lh),
                .left_valid (lv),
                .left_gt    (lg),
                .right_hit  (rh),
                .right_valid(rv),
                .hit        (hits[i]),
                .valid      (valids[i]),
                .gt         (gts[i])
            );

            if (i > 0) begin : g_chk
                `DHC_ASSERT_NOW(a_fill_contiguous, valids[i], valids[i-1], "stored hits not packed at head")
            end
        end
    endgenerate

    assign head_hit = hits[0];

endmodule

@@ sv/dhc_walk.sv @@
// ----------------------------------------------------------------------------
// Hit clustering walker
// Consumes sorted hits from the chain head, grows the open cluster, and
// loads finished clusters into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "detector_hit_clustering_defines.svh"

module dhc_walk import dhc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  walk_step_t            step,
    input  hit_t                  head_hit,
    input  logic [5:0]            layer_index,
    input  logic                  eta_side,
    input  logic [CH_W-1:0]       channel_gap,
    input  logic [TM_W-1:0]       time_window,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    logic [CNT_W-1:0] open_cnt_reg, open_cnt_next;
    logic             ovf_reg, ovf_next;
    logic [TOT_W-1:0] best_tot_reg, best_tot_next;
    logic [CH_W-1:0]  best_ch_reg, best_ch_next;
    logic [TM_W-1:0]  first_tm_reg, first_tm_next;
    logic [CH_W-1:0]  first_ch_reg, first_ch_next;
    logic [TOT_W-1:0] first_tot_reg, first_tot_next;
    logic [CH_W-1:0]  low_reg, low_next;
    logic [CH_W-1:0]  high_reg, high_next;
    logic [CH_W-1:0]  prev_ch_reg, prev_ch_next;
    logic [TM_W-1:0]  prev_tm_reg, prev_tm_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic [CH_W-1:0] dc;
    logic [TM_W-1:0] dt;
    logic            brk;
    logic            emit;
    logic            open_real;

    always_comb begin
        out_free  = !m_tvalid_reg || m_tready;
        dc        = (head_hit.ch >= prev_ch_reg) ? head_hit.ch - prev_ch_reg
                                                 : prev_ch_reg - head_hit.ch;
        dt        = (head_hit.tm >= prev_tm_reg) ? head_hit.tm - prev_tm_reg
                                                 : prev_tm_reg - head_hit.tm;
        open_real = (open_cnt_reg != '0);
        brk       = !open_real || (dc > channel_gap) || (dt > time_window);
        emit      = (step.hit_en && brk && open_real) || step.flush_en;

        open_cnt_next  = open_cnt_reg;
        ovf_next       = ovf_reg;
        best_tot_next  = best_tot_reg;
        best_ch_next   = best_ch_reg;
        first_tm_next  = first_tm_reg;
        first_ch_next  = first_ch_reg;
        first_tot_next = first_tot_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        prev_ch_next   = prev_ch_reg;
        prev_tm_next   = prev_tm_reg;

        if (step.start) begin
            open_cnt_next = '0;
            ovf_next      = step.ovf;
        end

        if (step.hit_en) begin
            if (brk) begin
                open_cnt_next  = CNT_W'(1);
                best_tot_next  = head_hit.tot;
                best_ch_next   = head_hit.ch;
                first_tm_next  = head_hit.tm;
                first_ch_next  = head_hit.ch;
                first_tot_next = head_hit.tot;
                low_next       = head_hit.ch;
                high_next      = head_hit.ch;
            end else begin
                open_cnt_next = open_cnt_reg + CNT_W'(1);
                if (head_hit.tot > best_tot_reg) begin
                    best_tot_next = head_hit.tot;
                    best_ch_next  = head_hit.ch;
                end
                if (head_hit.tm < first_tm_reg) begin
                    first_tm_next  = head_hit.tm;
                    first_ch_next  = head_hit.ch;
                    first_tot_next = head_hit.tot;
                end
                if (head_hit.ch < low_reg) begin
                    low_next = head_hit.ch;
                end
                if (head_hit.ch > high_reg) begin
                    high_next = head_hit.ch;
                end
            end
            prev_ch_next = head_hit.ch;
            prev_tm_next = head_hit.tm;
        end

        if (step.flush_en) begin
            open_cnt_next = '0;
        end

        // output beat: the cluster that was open before this step
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = step.flush_en;
            m_tuser_next  = open_real;
            if (open_real) begin
                m_tdata_next = {ovf_reg, (first_ch_reg != best_ch_reg), high_reg, low_reg,
                                MCNT_W'(open_cnt_reg), first_tot_reg, first_tm_reg,
                                best_ch_reg, eta_side, layer_index};
            end else begin
                m_tdata_next = {ovf_reg, 72'd0, eta_side, layer_index};
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            open_cnt_reg <= open_cnt_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_tot_reg  <= best_tot_next;
        best_ch_reg   <= best_ch_next;
        first_tm_reg  <= first_tm_next;
        first_ch_reg  <= first_ch_next;
        first_tot_reg <= first_tot_next;
        low_reg       <= low_next;
        high_reg      <= high_next;
        prev_ch_reg   <= prev_ch_next;
        prev_tm_reg   <= prev_tm_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `DHC_ASSERT_NOW(a_step_exclusive, step.hit_en, !step.flush_en && !step.start, "walk step overlaps flush or start")
    `DHC_ASSERT_NOW(a_open_bound, 1'b1, open_cnt_reg <= CNT_W'(MAX_HITS), "open cluster larger than store")

endmodule

@@ sv/detector_hit_clustering.sv @@
// ----------------------------------------------------------------------------
// Strip detector hit clustering
// Sorts one set of hits in a cell chain and emits clusters at end of set.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per command. tuser = 0 adds a hit from tdata, tuser = 1
//   ends the set. Hits with a negative time or a non-positive TOT are dropped;
//   hits beyond MAX_HITS stored are dropped and flag overflow.
//   Hits are taken one per cycle while the block is idle: each beat inserts into
//   the sort chain in the cycle it is accepted.
//   End of set: the chain shifts one stored hit per cycle into the cluster
//   walker while the output register is free; a cluster beat is loaded when a
//   step closes the open cluster and when the walk flushes the last one.
//   s_tready stays low from the end beat until the last result is loaded.
//   m_ channel: one beat per cluster, tlast on the final one of the set; an
//   empty set gives one beat with tuser (cluster valid) low.
//   A stall on m_tready holds the output register and freezes the walk.
//   Reset empties the chain and loads register defaults (gap 2, window 240).
//   Registers must be written over APB only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "detector_hit_clustering_defines.svh"

module detector_hit_clustering import dhc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // hit input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [9:0] channel, [29:10] leading_time, [45:30] time_over_threshold, [47:46] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] command
    input  logic                  s_tuser,
    // cluster output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [5:0] cluster_layer, [6] cluster_side, [16:7] center_channel,
    // [35:17] cluster_time, [50:36] cluster_tot, [57:51] member_count,
    // [67:58] low_channel, [77:68] high_channel, [78] center_not_earliest,
    // [79] overflow
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    // [0] cluster_valid
    output logic                  m_tuser
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;

    logic [5:0]       layer_reg, layer_next;
    logic             side_reg, side_next;
    logic [CH_W-1:0]  gap_reg, gap_next;
    logic [TM_W-1:0]  window_reg, window_next;

    logic             cfg_wr;
    logic             in_acc;
    logic             keep;
    logic [19:0]      in_time;
    logic [15:0]      in_tot;
    hit_t             new_hit;
    hit_t             head_hit;
    cell_ctl_t        cell_ctl;
    walk_step_t       step;
    logic             out_free;

    // configuration registers
    always_comb begin
        pready      = 1'b1;
        cfg_wr      = psel && penable && pwrite;
        layer_next  = layer_reg;
        side_next   = side_reg;
        gap_next    = gap_reg;
        window_next = window_reg;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LAYER:  layer_next  = pwdata[5:0];
                REG_SIDE:   side_next   = pwdata[0];
                REG_GAP:    gap_next    = pwdata[CH_W-1:0];
                REG_WINDOW: window_next = pwdata[TM_W-1:0];
                default:    ;
            endcase
        end
        unique case (paddr[3:2])
            REG_LAYER:  prdata = {26'd0, layer_reg};
            REG_SIDE:   prdata = {31'd0, side_reg};
            REG_GAP:    prdata = {22'd0, gap_reg};
            REG_WINDOW: prdata = {13'd0, window_reg};
            default:    prdata = '0;
        endcase
    end

    // input decode and sequencing
    always_comb begin
        s_tready    = (state_reg == ST_IDLE);
        in_acc      = s_tvalid && s_tready;
        in_time     = s_tdata[29:10];
        in_tot      = s_tdata[45:30];
        keep        = !in_time[19] && !in_tot[15] && (in_tot != 16'd0);
        new_hit.ch  = s_tdata[CH_W-1:0] & CH_MASK;
        new_hit.tm  = in_time[TM_W-1:0];
        new_hit.tot = in_tot[TOT_W-1:0];

        cell_ctl.ins   = in_acc && !s_tuser && keep && (cnt_reg < CNT_W'(MAX_HITS));
        cell_ctl.shift = (state_reg == ST_WALK) && out_free;

        step.start    = in_acc && s_tuser;
        step.ovf      = ovf_reg;
        step.hit_en   = cell_ctl.shift;
        step.flush_en = (state_reg == ST_FLUSH) && out_free;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (cell_ctl.ins) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end else if (in_acc && !s_tuser && keep) begin
                    ovf_next = 1'b1;
                end
                if (step.start) begin
                    ovf_next   = 1'b0;
                    state_next = (cnt_reg != '0) ? ST_WALK : ST_FLUSH;
                end
            end
            ST_WALK: begin
                if (step.hit_en) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (step.flush_en) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            layer_reg  <= 6'd0;
            side_reg   <= 1'b0;
            gap_reg    <= CH_W'(2);
            window_reg <= TM_W'(240);
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            layer_reg  <= layer_next;
            side_reg   <= side_next;
            gap_reg    <= gap_next;
            window_reg <= window_next;
        end
    end

    dhc_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cell_ctl),
        .new_hit (new_hit),
        .head_hit(head_hit)
    );

    dhc_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .head_hit   (head_hit),
        .layer_index(layer_reg),
        .eta_side   (side_reg),
        .channel_gap(gap_reg),
        .time_window(window_reg),
        .out_free   (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    `DHC_ASSERT_NOW(a_walk_has_hits, state_reg == ST_WALK, cnt_reg != '0, "walk with empty store")
    `DHC_ASSERT_NOW(a_count_bound, 1'b1, cnt_reg <= CNT_W'(MAX_HITS), "stored count beyond capacity")

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Hit clustering testbench
// Streams sets of strip hits into the clustering block and checks every
// cluster beat against an in-bench sorter and cluster walker. Directed hits
// cover the field extremes, the filter rules, tie ordering and the empty set.
// Random sets follow under three idling mixes and several register settings,
// with one long output hold-off and one full store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import dhc_pkg::*;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_END = 1'b1;
    localparam int   HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  ch;
        logic [19:0] tm;
        logic [15:0] tot;
    } strip_beat_t;

    // m_tdata layout, highest field first
    typedef struct packed {
        logic        ovf;
        logic        cne;
        logic [9:0]  high;
        logic [9:0]  low;
        logic [6:0]  count;
        logic [14:0] tot;
        logic [18:0] tm;
        logic [9:0]  center;
        logic        side;
        logic [5:0]  layer;
    } cluster_t;

    typedef struct packed {
        logic     valid;
        logic     last;
        cluster_t body;
    } cluster_beat_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [3:0]            paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    detector_hit_clustering dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // register shadows
    logic [5:0]  cfg_layer  = 6'd0;
    logic        cfg_side   = 1'b0;
    logic [9:0]  cfg_gap    = 10'd2;
    logic [18:0] cfg_window = 19'd240;

    // sorted hit store and cluster under construction
    hit_t     hit_store[$];
    logic     store_ovf = 1'b0;
    cluster_t open_cl;
    logic [9:0] open_first_ch;

    strip_beat_t   pending_beats[$];
    cluster_beat_t expected_clusters[$];
    int strip_beats_queued = 0;
    int strip_beats_taken  = 0;
    int mismatches         = 0;
    int send_idle_pct      = 12;
    int recv_idle_pct      = 85;
    int stall_requests     = 0;
    logic s_took = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("detector_hit_clustering regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------ predictor

    task automatic sort_in_hit(input strip_beat_t b);
        hit_t h;
        int   pos;
        h.ch  = b.ch & CH_MASK;
        h.tm  = b.tm[18:0];
        h.tot = b.tot[14:0];
        // drop negative time, non-positive TOT
        if (b.tm[19] || b.tot[15] || b.tot == 16'd0) begin
        end else if (hit_store.size() >= MAX_HITS) begin
            store_ovf = 1'b1;
        end else begin
            pos = hit_store.size();
            while (pos > 0 && (hit_store[pos-1].ch > h.ch ||
                   (hit_store[pos-1].ch == h.ch && hit_store[pos-1].tm > h.tm)))
                pos--;
            hit_store.insert(pos, h);
        end
    endtask

    task automatic expect_cluster(input cluster_beat_t e);
        expected_clusters.insert(expected_clusters.size(), e);
    endtask

    function automatic cluster_beat_t close_cluster(input logic last);
        cluster_beat_t e;
        e        = '0;
        e.valid  = 1'b1;
        e.last   = last;
        e.body   = open_cl;
        e.body.layer = cfg_layer;
        e.body.side  = cfg_side;
        e.body.cne   = (open_first_ch != open_cl.center);
        e.body.ovf   = store_ovf;
        return e;
    endfunction

    // running best TOT of the open cluster, indexed by walk position
    logic [14:0] best_tot_run[MAX_HITS];

    function automatic logic [14:0] best_tot_of(input int idx);
        return best_tot_run[idx-1];
    endfunction

    task automatic best_tot_track(input int idx);
        hit_t h;
        h = hit_store[idx];
        if (open_cl.count == 7'd1)
            best_tot_run[idx] = h.tot;
        else
            best_tot_run[idx] = (h.tot > best_tot_run[idx-1]) ? h.tot : best_tot_run[idx-1];
    endtask

    task automatic walk_clusters();
        cluster_beat_t e;
        hit_t          h;
        logic [9:0]    prev_ch, dc;
        logic [18:0]   prev_tm, dt;
        prev_ch = '0;
        prev_tm = '0;
        open_cl = '0;
        if (hit_store.size() == 0) begin
            e = '0;
            e.last       = 1'b1;
            e.body.layer = cfg_layer;
            e.body.side  = cfg_side;
            e.body.ovf   = store_ovf;
            expect_cluster(e);
        end else begin
            foreach (hit_store[i]) begin
                h  = hit_store[i];
                dc = (h.ch >= prev_ch) ? h.ch - prev_ch : prev_ch - h.ch;
                dt = (h.tm >= prev_tm) ? h.tm - prev_tm : prev_tm - h.tm;
                if (open_cl.count == 0 || dc > cfg_gap || dt > cfg_window) begin
                    if (open_cl.count != 0)
                        expect_cluster(close_cluster(1'b0));
                    open_cl        = '0;
                    open_cl.count  = 7'd1;
                    open_cl.center = h.ch;
                    open_cl.tm     = h.tm;
                    open_cl.tot    = h.tot;
                    open_cl.low    = h.ch;
                    open_cl.high   = h.ch;
                    open_first_ch  = h.ch;
                end else begin
                    open_cl.count++;
                    // center tracks highest TOT; open_cl.tot is the earliest hit's TOT
                    if (h.tot > best_tot_of(i)) open_cl.center = h.ch;
                    if (h.tm < open_cl.tm) begin
                        open_cl.tm    = h.tm;
                        open_cl.tot   = h.tot;
                        open_first_ch = h.ch;
                    end
                    if (h.ch < open_cl.low)  open_cl.low  = h.ch;
                    if (h.ch > open_cl.high) open_cl.high = h.ch;
                end
                best_tot_track(i);
                prev_ch = h.ch;
                prev_tm = h.tm;
            end
            expect_cluster(close_cluster(1'b1));
        end
        hit_store.delete();
        store_ovf = 1'b0;
    endtask

    // ------------------------------------------------------------------ checking

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_cluster(input cluster_beat_t got);
        cluster_beat_t want;
        if (expected_clusters.size() == 0) begin
            $display("%0t: cluster beat with none expected, expected nothing got %h",
                     $time, got);
            mismatches++;
        end else begin
            want = expected_clusters.pop_front();
            check_field("cluster_valid", want.valid, got.valid);
            check_field("last_cluster", want.last, got.last);
            check_field("cluster_layer", want.body.layer, got.body.layer);
            check_field("cluster_side", want.body.side, got.body.side);
            check_field("center_channel", want.body.center, got.body.center);
            check_field("cluster_time", want.body.tm, got.body.tm);
            check_field("cluster_tot", want.body.tot, got.body.tot);
            check_field("member_count", want.body.count, got.body.count);
            check_field("low_channel", want.body.low, got.body.low);
            check_field("high_channel", want.body.high, got.body.high);
            check_field("center_not_earliest", want.body.cne, got.body.cne);
            check_field("overflow", want.body.ovf, got.body.ovf);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
                check_cluster({m_tuser, m_tlast, cluster_t'(m_tdata)});
            if (s_tvalid && s_tready) begin
                strip_beats_taken++;
                if (s_tuser == CMD_END)
                    walk_clusters();
                else
                    sort_in_hit({s_tuser, s_tdata[9:0], s_tdata[29:10], s_tdata[45:30]});
            end
        end
    end

    // ------------------------------------------------------------------ driving

    always @(negedge aclk) begin
        strip_beat_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                b = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= b.cmd;
                s_tdata  <= {2'b00, b.tot, b.tm, b.ch};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(negedge aclk) begin
        int stalls_served;
        int hold_left;
        if (stall_requests != stalls_served) begin
            stalls_served = stall_requests;
            hold_left     = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------ stimulus

    task automatic queue_beat(input logic cmd, input logic [9:0] ch,
                              input logic [19:0] tm, input logic [15:0] tot);
        strip_beat_t b;
        b = {cmd, ch, tm, tot};
        pending_beats.insert(pending_beats.size(), b);
        strip_beats_queued++;
    endtask

    function automatic int set_size();
        return ($urandom_range(19) == 0) ? $urandom_range(30, 64) : $urandom_range(0, 12);
    endfunction

    task automatic queue_hit_set(input int n_hits);
        logic [9:0]  base_ch, ch;
        logic [18:0] base_tm;
        logic [19:0] tm;
        logic [15:0] tot;
        int          roll;
        int          i;
        base_ch = 10'($urandom);
        base_tm = 19'($urandom);
        ch  = base_ch;
        tm  = {1'b0, base_tm};
        tot = 16'd1;
        for (i = 0; i < n_hits; i++) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                ch  = 10'($urandom);
                tm  = 20'($urandom);
                tot = 16'($urandom);
            end else if (roll < 10) begin
                tot = 16'(0 - $urandom_range(32768));
            end else if (roll < 12) begin
                tm = 20'h80000 | 20'($urandom);
            end else if (roll < 20 && i > 0) begin
                // same channel and time as the previous hit
                tot = 16'($urandom_range(1, 32767));
            end else begin
                if ($urandom_range(3) == 0) begin
                    base_ch += 10'($urandom_range(1, 12));
                    base_tm += 19'($urandom_range(2000));
                end
                ch  = base_ch + 10'($urandom_range(3));
                tm  = {1'b0, base_tm + 19'($urandom_range(300))};
                tot = 16'($urandom_range(1, 32767));
            end
            queue_beat(CMD_ADD, ch, tm, tot);
        end
        queue_beat(CMD_END, 10'($urandom), 20'($urandom), 16'($urandom));
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LAYER:  cfg_layer  = value[5:0];
            REG_SIDE:   cfg_side   = value[0];
            REG_GAP:    cfg_gap    = value[9:0];
            REG_WINDOW: cfg_window = value[18:0];
            default: begin
            end
        endcase
    endtask

    task automatic wait_idle();
        while (strip_beats_taken != strip_beats_queued || expected_clusters.size() != 0)
            @(posedge aclk);
        // let any trailing add beats settle before touching registers
        repeat (16) @(posedge aclk);
    endtask

    initial begin
        int phase_start;
        int chunk;
        int i;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset register values (gap 2, window 240)
        queue_beat(CMD_END, '0, '0, '0);
        queue_beat(CMD_ADD, 10'd0, 20'd0, 16'd1);
        queue_beat(CMD_ADD, 10'd1023, 20'h7FFFF, 16'h7FFF);
        queue_beat(CMD_ADD, 10'd500, 20'd1000, 16'h0000);
        queue_beat(CMD_ADD, 10'd500, 20'd1000, 16'hFFFF);
        queue_beat(CMD_ADD, 10'd500, 20'h80000, 16'd100);
        queue_beat(CMD_ADD, 10'd500, 20'hFFFFF, 16'h8000);
        queue_beat(CMD_ADD, 10'd5, 20'd100, 16'd50);
        queue_beat(CMD_ADD, 10'd5, 20'd100, 16'd80);
        queue_beat(CMD_ADD, 10'd6, 20'd90, 16'd80);
        queue_beat(CMD_ADD, 10'd7, 20'd80, 16'd20);
        queue_beat(CMD_ADD, 10'd3, 20'd400, 16'd30);
        queue_beat(CMD_ADD, 10'd2, 20'd160, 16'd30);
        queue_beat(CMD_ADD, 10'd9, 20'd80, 16'd20);
        queue_beat(CMD_ADD, 10'd12, 20'd80, 16'd20);
        queue_beat(CMD_END, '1, '1, '1);
        queue_beat(CMD_END, '0, '0, '0);
        wait_idle();

        // smallest gap and window, slow receiver, full store under a long hold-off
        send_idle_pct = 12;
        recv_idle_pct = 85;
        apb_write(REG_LAYER, 32'd63);
        apb_write(REG_SIDE, 32'd1);
        apb_write(REG_GAP, 32'd0);
        apb_write(REG_WINDOW, 32'd0);
        stall_requests++;
        for (i = 0; i < MAX_HITS + 4; i++)
            queue_beat(CMD_ADD, 10'(i * 3), 20'($urandom_range(524287)),
                       16'($urandom_range(1, 32767)));
        queue_beat(CMD_END, '0, '0, '0);
        phase_start = strip_beats_queued;
        while (strip_beats_queued - phase_start < 60)
            queue_hit_set(set_size());
        wait_idle();

        // largest gap and window, slow sender
        send_idle_pct = 85;
        recv_idle_pct = 12;
        apb_write(REG_LAYER, 32'($urandom_range(63)));
        apb_write(REG_SIDE, 32'd0);
        apb_write(REG_GAP, 32'd1023);
        apb_write(REG_WINDOW, 32'd524287);
        phase_start = strip_beats_queued;
        while (strip_beats_queued - phase_start < 120)
            queue_hit_set(set_size());
        wait_idle();

        // no idling; sender pauses for all results between chunks
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (chunk = 0; chunk < 5; chunk++) begin
            apb_write(REG_LAYER, 32'($urandom_range(63)));
            apb_write(REG_SIDE, 32'($urandom_range(1)));
            apb_write(REG_GAP, 32'($urandom_range(1, 6)));
            apb_write(REG_WINDOW, 32'($urandom_range(16, 800)));
            phase_start = strip_beats_queued;
            while (strip_beats_queued - phase_start < 50)
                queue_hit_set(set_size());
            wait_idle();
        end

        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_clusters.size() == 0)
            $display("detector_hit_clustering regression: pass");
        else
            $display("detector_hit_clustering regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/dhc_pkg.sv
sv/dhc_cell.sv
sv/dhc_chain.sv
sv/dhc_walk.sv
sv/detector_hit_clustering.sv
tb/sv/tb_top.sv
